[hw/rtl/brui_pkg.sv]
// ----------------------------------------------------------------------------
// Range bucket index package
// Sizes, operation and status codes, and helper functions shared by the
// range bucket index block.
// ----------------------------------------------------------------------------
`default_nettype none

package brui_pkg;

  // Storage geometry.
  localparam int NumBuckets = 64;
  localparam int MaxRecords = 1024;
  localparam int MaskW      = 64;
  localparam int NumWords   = (MaxRecords + MaskW - 1) / MaskW;
  localparam int LaneW      = $clog2(MaskW);
  localparam int BktW       = $clog2(NumBuckets);
  localparam int WordW      = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int PosW       = $clog2(MaxRecords);
  localparam int CntW       = $clog2(MaxRecords + 1);
  localparam int AddrW      = BktW + WordW;
  localparam int MemDepth   = NumBuckets * NumWords;
  localparam int NbW        = BktW + 1;

  // Popcount is done one byte per cycle.
  localparam int ByteW      = 8;
  localparam int NumBytes   = MaskW / ByteW;
  localparam int ByteIdxW   = $clog2(NumBytes);

  // Port field widths.
  localparam int ModeW      = 2;
  localparam int RangeW     = 9;
  localparam int CfgW       = 7;
  localparam int StatusW    = 2;
  localparam int PosOutW    = 12;
  localparam int WordOutW   = 6;
  localparam int TotalW     = 13;

  // Signed width used for bucket versus bound compares.
  localparam int CmpW       = ((RangeW > NbW) ? RangeW : NbW) + 2;

  // Operation codes.
  localparam logic [ModeW-1:0] ModeStart  = 2'd0;
  localparam logic [ModeW-1:0] ModeInsert = 2'd1;
  localparam logic [ModeW-1:0] ModeExtIn  = 2'd2;
  localparam logic [ModeW-1:0] ModeExtOut = 2'd3;

  // Status codes.
  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusFull     = 2'd1;
  localparam logic [StatusW-1:0] StatusBadRange = 2'd2;

  function automatic logic [3:0] popcount8(input logic [ByteW-1:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < ByteW; i++) begin
      c = c + 4'(v[i]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bucket_range_index_union_core.sv]
// ----------------------------------------------------------------------------
// Range bucket index core
// Keeps one membership bitmap per bucket over record positions, inserts
// records into a span of buckets and returns unions over bucket ranges as a
// stream of membership words.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) takes one item: a mode and two
//   signed bucket bounds. Start clears the index, insert hands out the next
//   record position, and the two extract modes return a union of buckets.
//   The output channel (out_valid_o / out_ready_i) returns one item for start,
//   insert and any bad range, and one item per 64-position word (all words,
//   in increasing order, count on the last) for an extract.
//   The bucket_count register is written via cfg_valid_i / cfg_data_i, by the user
//   only while the block is idle (not enforced by it); cfg_ready_o is always high.
//   Start and rejected items pass from acceptance through the emit step into
//   the output register. An insert does one read-modify-write of the
//   addressed word in every bucket through the bitmap memory. An extract
//   builds its 16 words in increasing order, each by a read of every bucket,
//   one drain step, a popcount over each byte of the word and one emit step.
//   One item is in work at a time; a new item is taken once the last result
//   of the previous one sits in the output register.
//   Reset clears the record counter and sets bucket_count to 64. The memory
//   needs no clearing pass: words at or above the record counter read as
//   zero, and the first insert into a word rewrites that word in every bucket.
//   A stalled receiver holds the output register; the engine then waits in
//   its emit step with the next word ready.
// ----------------------------------------------------------------------------
`default_nettype none

module bucket_range_index_union_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Configuration write channel.
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [brui_pkg::CfgW-1:0]               cfg_data_i,
  // Input channel.
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [brui_pkg::ModeW-1:0]              mode_i,
  input  logic signed [brui_pkg::RangeW-1:0]      range_low_i,
  input  logic signed [brui_pkg::RangeW-1:0]      range_high_i,
  // Output channel.
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [brui_pkg::StatusW-1:0]            status_o,
  output logic [brui_pkg::PosOutW-1:0]            assigned_position_o,
  output logic [brui_pkg::WordOutW-1:0]           word_index_o,
  output logic [brui_pkg::MaskW-1:0]              member_mask_o,
  output logic [brui_pkg::TotalW-1:0]             total_found_o,
  output logic                                    last_o
);

  import brui_pkg::*;

  // Sequencer states.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StWait  = 3'd2;
  localparam logic [2:0] StCount = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  localparam logic [BktW-1:0]     LastBkt  = BktW'(NumBuckets - 1);
  localparam logic [WordW-1:0]    LastWord = WordW'(NumWords - 1);
  localparam logic [ByteIdxW-1:0] LastByte = ByteIdxW'(NumBytes - 1);

  logic [2:0]               state_q, state_d;
  logic [ModeW-1:0]         mode_q, mode_d;
  logic signed [RangeW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [StatusW-1:0]       st_q, st_d;
  logic [PosW-1:0]          pos_q, pos_d;
  logic                     ext_q, ext_d;
  logic [WordW-1:0]         word_q, word_d;
  logic [BktW-1:0]          bkt_q, bkt_d;
  logic [ByteIdxW-1:0]      byte_q, byte_d;
  logic [MaskW-1:0]         acc_q, acc_d;
  logic [CntW-1:0]          total_q, total_d;
  logic [CntW-1:0]          rec_cnt_q, rec_cnt_d;
  logic [CfgW-1:0]          bucket_count_q;
  logic                     rd_pend_q, rd_pend_d;
  logic [BktW-1:0]          rd_bkt_q, rd_bkt_d;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  logic [StatusW-1:0]       out_status_q, out_status_d;
  logic [PosOutW-1:0]       out_pos_q, out_pos_d;
  logic [WordOutW-1:0]      out_word_q, out_word_d;
  logic [MaskW-1:0]         out_mask_q, out_mask_d;
  logic [TotalW-1:0]        out_total_q, out_total_d;
  logic                     out_last_q, out_last_d;

  // Bitmap memory, addressed {bucket, word}.
  logic [MaskW-1:0]         mem [MemDepth];
  logic [MaskW-1:0]         mem_rdata_q;
  logic                     mem_re;
  logic [AddrW-1:0]         mem_raddr;
  logic                     mem_we;
  logic [AddrW-1:0]         mem_waddr;
  logic [MaskW-1:0]         mem_wdata;

  logic                     in_fire;
  logic                     out_slot;
  logic [NbW-1:0]           nb;
  logic signed [CmpW-1:0]   lo_x, hi_x, b_x;
  logic                     bkt_in_set;
  logic                     word_live;
  logic                     first_in_word;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_slot    = !out_valid_q || out_ready_i;

  // Effective bucket count: zero acts as one, anything above the store as the store.
  always_comb begin
    if (bucket_count_q == '0) begin
      nb = NbW'(1);
    end else if (NbW'(bucket_count_q) > NbW'(NumBuckets)) begin
      nb = NbW'(NumBuckets);
    end else begin
      nb = NbW'(bucket_count_q);
    end
  end

  // Membership of the bucket whose data returns this cycle. Out-of-range
  // bounds need no clamping: the compares against 0..nb-1 do the same job.
  assign lo_x = CmpW'(lo_q);
  assign hi_x = CmpW'(hi_q);
  assign b_x  = CmpW'(rd_bkt_q);

  always_comb begin
    bkt_in_set = 1'b0;
    if (NbW'(rd_bkt_q) < nb) begin
      if (mode_q == ModeExtOut) begin
        bkt_in_set = (b_x <= lo_x) || (b_x >= hi_x);
      end else begin
        bkt_in_set = (lo_x <= b_x) && (b_x <= hi_x);
      end
    end
  end

  // A word holds current data only once the counter has reached into it.
  assign word_live     = CntW'({word_q, LaneW'(0)}) < rec_cnt_q;
  assign first_in_word = (pos_q[LaneW-1:0] == '0);

  assign mem_re    = (state_q == StScan);
  assign mem_raddr = {bkt_q, word_q};
  assign mem_we    = rd_pend_q && (mode_q == ModeInsert);
  assign mem_waddr = {rd_bkt_q, word_q};

  // The first record of a word rewrites that word in every bucket, which
  // discards whatever an earlier fill left there.
  always_comb begin
    mem_wdata = first_in_word ? '0 : mem_rdata_q;
    if (bkt_in_set) begin
      mem_wdata = mem_wdata | (MaskW'(1) << pos_q[LaneW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    st_d        = st_q;
    pos_d       = pos_q;
    ext_d       = ext_q;
    word_d      = word_q;
    bkt_d       = bkt_q;
    byte_d      = byte_q;
    acc_d       = acc_q;
    total_d     = total_q;
    rec_cnt_d   = rec_cnt_q;
    rd_pend_d   = 1'b0;
    rd_bkt_d    = rd_bkt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_word_d   = out_word_q;
    out_mask_d   = out_mask_q;
    out_total_d  = out_total_q;
    out_last_d   = out_last_q;

    // Returning read data of extracts folds into the accumulator.
    if (rd_pend_q && ext_q && bkt_in_set && word_live) begin
      acc_d = acc_q | mem_rdata_q;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          mode_d  = mode_i;
          lo_d    = range_low_i;
          hi_d    = range_high_i;
          st_d    = StatusOk;
          pos_d   = '0;
          ext_d   = 1'b0;
          word_d  = '0;
          bkt_d   = '0;
          byte_d  = '0;
          acc_d   = '0;
          total_d = '0;
          if (mode_i == ModeStart) begin
            rec_cnt_d = '0;
            state_d   = StEmit;
          end else if (range_low_i > range_high_i) begin
            st_d    = StatusBadRange;
            state_d = StEmit;
          end else if (mode_i == ModeInsert) begin
            if (rec_cnt_q >= CntW'(MaxRecords)) begin
              st_d    = StatusFull;
              state_d = StEmit;
            end else begin
              pos_d     = rec_cnt_q[PosW-1:0];
              word_d    = WordW'(rec_cnt_q[PosW-1:LaneW]);
              rec_cnt_d = rec_cnt_q + CntW'(1);
              state_d   = StScan;
            end
          end else begin
            ext_d   = 1'b1;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        rd_pend_d = 1'b1;
        rd_bkt_d  = bkt_q;
        bkt_d     = bkt_q + BktW'(1);
        if (bkt_q == LastBkt) begin
          state_d = StWait;
        end
      end
      StWait: begin
        byte_d  = '0;
        state_d = ext_q ? StCount : StEmit;
      end
      StCount: begin
        total_d = total_q + CntW'(popcount8(acc_q[byte_q*ByteW +: ByteW]));
        byte_d  = byte_q + ByteIdxW'(1);
        if (byte_q == LastByte) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_slot) begin
          out_valid_d  = 1'b1;
          out_status_d = st_q;
          out_pos_d    = PosOutW'(pos_q);
          out_word_d   = ext_q ? WordOutW'(word_q) : '0;
          out_mask_d   = acc_q;
          out_last_d   = !ext_q || (word_q == LastWord);
          out_total_d  = (ext_q && (word_q == LastWord)) ? TotalW'(total_q) : '0;
          if (ext_q && (word_q != LastWord)) begin
            word_d  = word_q + WordW'(1);
            bkt_d   = '0;
            acc_d   = '0;
            state_d = StScan;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      rec_cnt_q      <= '0;
      bucket_count_q <= CfgW'(64);
      rd_pend_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      ext_q          <= 1'b0;
      mode_q         <= ModeStart;
    end else begin
      state_q     <= state_d;
      rec_cnt_q   <= rec_cnt_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      ext_q       <= ext_d;
      mode_q      <= mode_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bucket_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    st_q         <= st_d;
    pos_q        <= pos_d;
    word_q       <= word_d;
    bkt_q        <= bkt_d;
    byte_q       <= byte_d;
    acc_q        <= acc_d;
    total_q      <= total_d;
    rd_bkt_q     <= rd_bkt_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_word_q   <= out_word_d;
    out_mask_q   <= out_mask_d;
    out_total_q  <= out_total_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign assigned_position_o = out_pos_q;
  assign word_index_o        = out_word_q;
  assign member_mask_o       = out_mask_q;
  assign total_found_o       = out_total_q;
  assign last_o              = out_last_q;

  // The record counter never runs past the store.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_cnt_q <= CntW'(MaxRecords))
    else $error("record counter beyond capacity");

  // A start item leaves the counter at zero.
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (mode_i == ModeStart) |=> rec_cnt_q == '0)
    else $error("start did not clear the record counter");

  // Only inserts write the bitmap memory.
  a_write_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mode_q == ModeInsert) && !ext_q)
    else $error("bitmap write outside an insert");

  // The engine never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_mask_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range bucket index core testbench
// Drives start, insert and both extract modes through the valid/ready input
// channel and checks every returned item field by field against a predictor
// of the bucket bitmaps and the record counter kept here. A directed table
// opens the run; random phases under several bucket counts and a few
// extracts over the whole index follow.
// ----------------------------------------------------------------------------

module testbench;

  import brui_pkg::*;

  // Random phases, each run under its own bucket count setting.
  localparam int NumPhases    = 7;
  localparam int PhaseItems   = 60;
  localparam int NumSteps     = 25;
  // Receiver hold-off that backs the block up into its input channel.
  localparam int HoldCycles   = 400;
  // Quiet time after the last expected item.
  localparam int SettleCycles = 80;
  // Cycles without any handshake before the run is declared hung.
  localparam int StallLimit   = 4000;
  localparam int MaxReports   = 40;

  // One input item as offered on the input channel.
  typedef struct packed {
    logic [ModeW-1:0]         mode;
    logic signed [RangeW-1:0] lo;
    logic signed [RangeW-1:0] hi;
  } query_t;

  // One output item.
  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [PosOutW-1:0]  pos;
    logic [WordOutW-1:0] word;
    logic [MaskW-1:0]    mask;
    logic [TotalW-1:0]   total;
    logic                last;
  } result_t;

  // A row of the directed table. Where known is set, the row causes exactly
  // one output item and its status and position are typed in here.
  typedef struct packed {
    logic [ModeW-1:0]         mode;
    logic signed [RangeW-1:0] lo;
    logic signed [RangeW-1:0] hi;
    logic                     known;
    logic [StatusW-1:0]       status;
    logic [PosOutW-1:0]       pos;
  } step_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CfgW-1:0]           cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [ModeW-1:0]          mode_i;
  logic signed [RangeW-1:0]  range_low_i;
  logic signed [RangeW-1:0]  range_high_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [StatusW-1:0]        status_o;
  logic [PosOutW-1:0]        assigned_position_o;
  logic [WordOutW-1:0]       word_index_o;
  logic [MaskW-1:0]          member_mask_o;
  logic [TotalW-1:0]         total_found_o;
  logic                      last_o;

  // Predictor state: one bitmap per bucket over record positions, the next
  // free position, and the bucket_count register as last written.
  logic [MaskW-1:0] bitmap [NumBuckets][NumWords];
  logic [MaskW-1:0] union_acc [NumWords];
  int unsigned      rec_cnt;
  logic [CfgW-1:0]  bucket_cfg;

  // Output items still owed by the block, oldest first.
  result_t          owed_q [$];
  result_t          want_res;

  int               mismatch_cnt;
  int               stall_cycles;
  // steady turns idling off on both sides; hold_req asks the receiver for
  // one long hold-off while the sender keeps offering items.
  bit               steady;
  bit               hold_req;
  bit               hold_done;

  // The directed part: reset state, span and bound extremes, spans wholly
  // outside the buckets, bad ranges in insert and both extract modes, and each
  // extract-not-in case (both ends outside, low end only, high end only, neither).
  step_t steps [NumSteps] = '{
    '{ModeExtIn,  -256,  255, 1'b0, StatusOk,       0},
    '{ModeStart,     0,    0, 1'b1, StatusOk,       0},
    '{ModeInsert, -256,  255, 1'b1, StatusOk,       0},
    '{ModeInsert,    0,    0, 1'b1, StatusOk,       1},
    '{ModeInsert,   63,   63, 1'b1, StatusOk,       2},
    '{ModeInsert,   64,  255, 1'b1, StatusOk,       3},
    '{ModeInsert, -256,   -1, 1'b1, StatusOk,       4},
    '{ModeInsert,    5,    3, 1'b1, StatusBadRange, 0},
    '{ModeInsert,  255, -256, 1'b1, StatusBadRange, 0},
    '{ModeInsert,   10,   20, 1'b1, StatusOk,       5},
    '{ModeInsert,   -3,    2, 1'b1, StatusOk,       6},
    '{ModeExtIn,     0,    0, 1'b0, StatusOk,       0},
    '{ModeExtIn,  -256,  255, 1'b0, StatusOk,       0},
    '{ModeExtIn,    64,  255, 1'b0, StatusOk,       0},
    '{ModeExtIn,   -10,    5, 1'b0, StatusOk,       0},
    '{ModeExtIn,     9,    3, 1'b1, StatusBadRange, 0},
    '{ModeExtOut,   -1,   64, 1'b0, StatusOk,       0},
    '{ModeExtOut,   -5,   30, 1'b0, StatusOk,       0},
    '{ModeExtOut,   15,  100, 1'b0, StatusOk,       0},
    '{ModeExtOut,    5,   40, 1'b0, StatusOk,       0},
    '{ModeExtOut,    0,   63, 1'b0, StatusOk,       0},
    '{ModeExtOut,   40,   20, 1'b1, StatusBadRange, 0},
    '{ModeExtOut, -256, -256, 1'b0, StatusOk,       0},
    '{ModeStart,     0,    0, 1'b1, StatusOk,       0},
    '{ModeInsert,    0,   63, 1'b1, StatusOk,       0}
  };

  bucket_range_index_union_core i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .mode_i              (mode_i),
    .range_low_i         (range_low_i),
    .range_high_i        (range_high_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .assigned_position_o (assigned_position_o),
    .word_index_o        (word_index_o),
    .member_mask_o       (member_mask_o),
    .total_found_o       (total_found_o),
    .last_o              (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // A register value of zero still means one bucket, and anything above the
  // built-in bucket count is cut down to it.
  function automatic int active_buckets();
    if (bucket_cfg == '0) begin
      return 1;
    end
    if (int'(bucket_cfg) > NumBuckets) begin
      return NumBuckets;
    end
    return int'(bucket_cfg);
  endfunction

  function automatic void clear_index();
    foreach (bitmap[b, w]) begin
      bitmap[b][w] = '0;
    end
    rec_cnt = 0;
  endfunction

  // OR the buckets lo..hi into union_acc after clamping to the buckets in
  // use. A range that misses the buckets entirely adds nothing.
  function automatic void or_range(input int lo, input int hi);
    int nb;
    nb = active_buckets();
    if (lo > nb - 1 || hi < 0 || lo > hi) begin
      return;
    end
    if (hi > nb - 1) begin
      hi = nb - 1;
    end
    if (lo < 0) begin
      lo = 0;
    end
    for (int b = lo; b <= hi; b++) begin
      for (int w = 0; w < NumWords; w++) begin
        union_acc[w] |= bitmap[b][w];
      end
    end
  endfunction

  // Update the predicted index for one accepted item and queue the output
  // items it owes.
  function automatic void predict_item(input query_t q);
    int          lo;
    int          hi;
    int          nb;
    int          first;
    int          final_b;
    int unsigned total;
    result_t     r;
    lo   = $signed(q.lo);
    hi   = $signed(q.hi);
    nb   = active_buckets();
    r    = '0;
    r.last = 1'b1;
    if (q.mode == ModeStart) begin
      clear_index();
      owed_q.push_back(r);
      return;
    end
    // A bad range is caught before anything else in every other mode.
    if (lo > hi) begin
      r.status = StatusBadRange;
      owed_q.push_back(r);
      return;
    end
    if (q.mode == ModeInsert) begin
      if (rec_cnt >= MaxRecords) begin
        r.status = StatusFull;
        owed_q.push_back(r);
        return;
      end
      // A span wholly outside the buckets still uses up a position.
      if (!(lo > nb - 1 || hi < 0)) begin
        first   = (lo < 0) ? 0 : lo;
        final_b = (hi > nb - 1) ? nb - 1 : hi;
        for (int b = first; b <= final_b; b++) begin
          bitmap[b][rec_cnt / MaskW][rec_cnt % MaskW] = 1'b1;
        end
      end
      r.pos   = PosOutW'(rec_cnt);
      rec_cnt = rec_cnt + 1;
      owed_q.push_back(r);
      return;
    end
    foreach (union_acc[w]) begin
      union_acc[w] = '0;
    end
    if (q.mode == ModeExtIn) begin
      or_range(lo, hi);
    end else if (lo < 0 && hi > nb - 1) begin
      // Both ends outside: the complement is empty.
    end else if (lo < 0) begin
      or_range(hi, nb - 1);
    end else if (hi > nb - 1) begin
      or_range(0, lo);
    end else begin
      or_range(0, lo);
      or_range(hi, nb - 1);
    end
    total = 0;
    foreach (union_acc[w]) begin
      total += $countones(union_acc[w]);
    end
    // Every word of the union goes out, the count only on the final one.
    for (int w = 0; w < NumWords; w++) begin
      r.word  = WordOutW'(w);
      r.mask  = union_acc[w];
      r.last  = (w == NumWords - 1);
      r.total = r.last ? TotalW'(total) : '0;
      owed_q.push_back(r);
    end
  endfunction

  // Mostly inserts and extracts over bounds near the buckets in use, with a
  // few starts, some bad ranges and some bounds of any bit pattern.
  function automatic query_t random_query();
    query_t q;
    int     nb;
    int     lo;
    int     hi;
    int     pick;
    nb   = active_buckets();
    pick = $urandom_range(99);
    q.mode = (pick < 4)  ? ModeStart  :
             (pick < 58) ? ModeInsert :
             (pick < 80) ? ModeExtIn  : ModeExtOut;
    if ($urandom_range(9) == 0) begin
      q.lo = RangeW'($urandom);
      q.hi = RangeW'($urandom);
    end else begin
      lo = int'($urandom_range(nb + 7)) - 4;
      hi = lo + int'($urandom_range(nb / 2 + 3));
      if ($urandom_range(19) == 0) begin
        hi = lo - 1 - int'($urandom_range(5));
      end
      q.lo = RangeW'(lo);
      q.hi = RangeW'(hi);
    end
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Offer one item and hold it until accepted. Before the item the sender
  // may go quiet for a short or a long gap, so that gaps land at different
  // points of the block's work on the previous item.
  task automatic send_query(input query_t q, input logic known, input result_t want);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 34) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 3);
    end
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= q.mode;
    range_low_i  <= q.lo;
    range_high_i <= q.hi;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    predict_item(q);
    if (known) begin
      owed_q[owed_q.size() - 1] = want;
    end
  endtask

  // Stop offering items, wait until every owed item has come back, then let
  // the block settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (owed_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // The register is only written while the block has nothing in work.
  task automatic write_bucket_count(input logic [CfgW-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    bucket_cfg  = value;
  endtask

  initial begin : stimulus
    query_t          q;
    result_t         want;
    logic [CfgW-1:0] cfg_plan [NumPhases];
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    mode_i       = ModeStart;
    range_low_i  = '0;
    range_high_i = '0;
    steady       = 1'b0;
    hold_req     = 1'b0;
    mismatch_cnt = 0;
    clear_index();
    bucket_cfg   = 7'd64;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under the reset bucket count.
    foreach (steps[i]) begin
      q.mode = steps[i].mode;
      q.lo   = steps[i].lo;
      q.hi   = steps[i].hi;
      want        = '0;
      want.status = steps[i].status;
      want.pos    = steps[i].pos;
      want.last   = 1'b1;
      send_query(q, steps[i].known, want);
    end

    // Random phases. The index is not cleared between phases, so a smaller
    // bucket count also clamps over buckets filled under a larger one. The
    // register write before each phase doubles as a full pause of the sender.
    cfg_plan = '{7'd64, 7'd0, 7'd1, 7'd127, 7'd0, 7'd0, 7'd0};
    cfg_plan[4] = CfgW'($urandom_range(2, 63));
    cfg_plan[5] = CfgW'($urandom_range(65, 126));
    cfg_plan[6] = CfgW'($urandom_range(1, 64));
    for (int p = 0; p < NumPhases; p++) begin
      write_bucket_count(cfg_plan[p]);
      steady = (p == 3);
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 1 && i == 20) begin
          hold_req = 1'b1;
        end
        send_query(random_query(), 1'b0, '0);
      end
    end
    steady = 1'b0;

    // Extract over every bucket and over two inner spans of the index as the
    // random phases left it.
    write_bucket_count(7'd64);
    q = '{ModeExtIn, -9'sd256, 9'sd255};
    send_query(q, 1'b0, '0);
    q = '{ModeExtIn, 9'sd20, 9'sd30};
    send_query(q, 1'b0, '0);
    q = '{ModeExtOut, 9'sd10, 9'sd50};
    send_query(q, 1'b0, '0);

    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, one long hold-off on request, none at
  // all while the steady stretch runs.
  // --------------------------------------------------------------------------
  initial begin : receiver
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= steady || ($urandom_range(99) >= 34);
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [MaskW-1:0] want,
                             input logic [MaskW-1:0] got);
    if (got !== want) begin
      if (mismatch_cnt < MaxReports) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
      mismatch_cnt++;
    end
  endtask

  // Each accepted output item is compared against the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_q.size() == 0) begin
        if (mismatch_cnt < MaxReports) begin
          $display("%0t: output item with none owed, expected nothing, got word %0d",
                   $time, word_index_o);
        end
        mismatch_cnt++;
      end else begin
        want_res = owed_q.pop_front();
        check_field("status", MaskW'(want_res.status), MaskW'(status_o));
        check_field("assigned_position", MaskW'(want_res.pos), MaskW'(assigned_position_o));
        check_field("word_index", MaskW'(want_res.word), MaskW'(word_index_o));
        check_field("member_mask", want_res.mask, member_mask_o);
        check_field("total_found", MaskW'(want_res.total), MaskW'(total_found_o));
        check_field("last", MaskW'(want_res.last), MaskW'(last_o));
      end
    end
  end

  // A hung block shows up as a long run of cycles with no handshake at all.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("testbench failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
